// ----- rtl/rpn_pkg.sv -----
// ============================================================================
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
// ============================================================================
`default_nettype none

package rpn_pkg;

    // Item types of the two channels
    typedef struct packed {
        logic [7:0] ch;
        logic       token_end;
        logic       expr_end;
    } char_item_t;

    typedef struct packed {
        logic signed [63:0] total;
        logic signed [39:0] total_int;
        logic [1:0]         status;
    } result_item_t;

    // Arithmetic unit request
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    // Arithmetic operations
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    // Token kinds
    localparam logic [2:0] KIND_IDLE = 3'd0;
    localparam logic [2:0] KIND_NUM  = 3'd1;
    localparam logic [2:0] KIND_ADD  = 3'd2;
    localparam logic [2:0] KIND_MUL  = 3'd3;
    localparam logic [2:0] KIND_SUB  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;
    localparam logic [1:0] ST_UNF   = 2'd3;

    // Characters
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_TIMES = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Number accumulation
    localparam int         MANT_W     = 40;
    localparam int         FDIG_W     = 5;
    localparam logic [4:0] FDIG_MAX   = 5'd31;

    // Scaler: working word covers a 40-bit mantissa shifted by up to 32 bits
    localparam int          SCALE_W    = 72;
    localparam int          CHUNK_W    = 24;
    localparam int          CHUNKS     = SCALE_W / CHUNK_W;
    localparam int          DIV_IN_W   = CHUNK_W + 4;
    localparam int          DIV_PROD_W = DIV_IN_W + 32;
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SH   = 35;

    // Saturation limits
    localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT40_MAXU = 64'h0000_007F_FFFF_FFFF;
    localparam logic [63:0] INT40_MINU = 64'h0000_0080_0000_0000;

endpackage

`default_nettype wire

// ----- rtl/rpn_stack_mem.sv -----
// ============================================================================
// rpn_stack_mem
// Value stack storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module rpn_stack_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [63:0]       wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]            rd_data
);

    logic [63:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/rpn_scale.sv -----
// ============================================================================
// rpn_scale
// Turns a decimal mantissa into fixed point: shifts it up by the fraction
// bits, then divides by ten once per fraction digit, one 24-bit chunk a cycle.
// ============================================================================
`default_nettype none

module rpn_scale #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rpn_pkg::MANT_W-1:0] mant,
    input  wire logic [rpn_pkg::FDIG_W-1:0] digits,
    output logic                            done,
    output logic signed [63:0]              value
);
    import rpn_pkg::*;

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [FDIG_W-1:0]  dcnt_reg,  dcnt_next;
    logic [1:0]         ccnt_reg,  ccnt_next;
    logic [SCALE_W-1:0] work_reg;
    logic [3:0]         rem_reg;
    logic [63:0]        value_reg;

    logic [DIV_IN_W-1:0]   div_in;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [CHUNK_W-1:0]    quot;
    logic [DIV_IN_W-1:0]   quot10;
    logic [3:0]            rem_new;
    logic                  last_chunk;

    // One chunk of long division by ten via reciprocal multiply
    assign div_in     = {rem_reg, work_reg[SCALE_W-1 -: CHUNK_W]};
    assign div_prod   = div_in * RECIP10;
    assign quot       = div_prod[RECIP_SH +: CHUNK_W];
    assign quot10     = DIV_IN_W'({quot, 3'b000}) + DIV_IN_W'({quot, 1'b0});
    assign rem_new    = 4'(div_in - quot10);
    assign last_chunk = (ccnt_reg == 2'(CHUNKS - 1));

    // Control sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dcnt_next = dcnt_reg;
        ccnt_next = ccnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            dcnt_next = digits;
            ccnt_next = 2'd0;
        end
        else if (busy_reg)
        begin
            if (dcnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (last_chunk)
            begin
                ccnt_next = 2'd0;
                dcnt_next = dcnt_reg - FDIG_W'(1);
            end
            else
            begin
                ccnt_next = ccnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
            ccnt_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dcnt_reg <= dcnt_next;
            ccnt_reg <= ccnt_next;
        end
    end

    // Working word, remainder and result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= SCALE_W'(mant) << FRACTION_BITS;
            rem_reg  <= 4'd0;
        end
        else if (busy_reg)
        begin
            if (dcnt_reg == '0)
            begin
                value_reg <= (|work_reg[SCALE_W-1:63]) ? INT64_MAX : work_reg[63:0];
            end
            else
            begin
                work_reg <= {work_reg[SCALE_W-CHUNK_W-1:0], quot};
                rem_reg  <= last_chunk ? 4'd0 : rem_new;
            end
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

// ----- rtl/rpn_alu.sv -----
// ============================================================================
// rpn_alu
// Saturating add, subtract and fixed-point multiply of two stack values.
// Multiply builds the 128-bit product from four 32x32 partial products.
// ============================================================================
`default_nettype none

module rpn_alu #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rpn_pkg::alu_req_t req,
    input  wire logic [63:0]       a,
    input  wire logic [63:0]       b,
    output logic                   done,
    output logic [63:0]            result
);
    import rpn_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_FIN  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [1:0]   step_reg,  step_next;
    logic         done_reg,  done_next;
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  res_reg;

    logic [63:0]  sum, diff, addsub;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [63:0]  trunc, limit, mag_sat;
    logic         top_nz;

    // Saturating add and subtract
    assign sum  = a + b;
    assign diff = a - b;
    always_comb
    begin
        if (req.op == OP_SUB)
        begin
            if ((a[63] != b[63]) && (diff[63] != a[63]))
                addsub = a[63] ? INT64_MIN : INT64_MAX;
            else
                addsub = diff;
        end
        else
        begin
            if ((a[63] == b[63]) && (sum[63] != a[63]))
                addsub = a[63] ? INT64_MIN : INT64_MAX;
            else
                addsub = sum;
        end
    end

    // Partial product for this step: a half by step[1], b half by step[0]
    assign pa = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign pb = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp = pa * pb;
    always_comb
    begin
        case (step_reg)
            2'd0:    pp_shift = {64'd0, pp};
            2'd3:    pp_shift = {pp, 64'd0};
            default: pp_shift = {32'd0, pp, 32'd0};
        endcase
    end

    // Drop fraction bits of the product and saturate the magnitude
    assign trunc   = 64'(acc_reg >> FRACTION_BITS);
    assign top_nz  = |(acc_reg >> (64 + FRACTION_BITS));
    assign limit   = neg_reg ? INT64_MIN : INT64_MAX;
    assign mag_sat = (top_nz || (trunc > limit)) ? limit : trunc;

    // Sequencing
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_MUL)
                    begin
                        state_next = A_MUL;
                        step_next  = 2'd0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            A_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Operands, product accumulator and result
    always_ff @(posedge clk)
    begin
        if ((state_reg == A_IDLE) && req.start)
        begin
            if (req.op == OP_MUL)
            begin
                ma_reg  <= a[63] ? (64'd0 - a) : a;
                mb_reg  <= b[63] ? (64'd0 - b) : b;
                neg_reg <= a[63] ^ b[63];
                acc_reg <= '0;
            end
            else
            begin
                res_reg <= addsub;
            end
        end
        else if (state_reg == A_MUL)
        begin
            acc_reg <= acc_reg + pp_shift;
        end
        else if (state_reg == A_FIN)
        begin
            res_reg <= neg_reg ? (64'd0 - mag_sat) : mag_sat;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_calculator.sv -----
// ============================================================================
// rpn_stack_calculator
// Reverse Polish expression evaluator over a character stream, fixed point.
// ============================================================================
//
// Usage:
//   char channel: one ASCII character per item, with token_end marking the
//   last character of a token and expr_end the last of the expression.
//   result channel: one item per expression, the popped total, its integer
//   part and a status code (ok, bad number, stack overflow, stack underflow).
// Sequencing:
//   A character that ends no token is taken without leaving the idle state. A
//   number token end runs the divide-by-ten scaler, once per fraction digit;
//   an add, subtract or multiply runs two sequential stack reads, the
//   arithmetic unit and the write-back. Expression end adds the top-of-stack
//   read and result formatting; the read is skipped when an error is set or
//   the stack is empty.
// Reset:
//   Clears the stack pointer, token state and errors. The stack memory is not
//   cleared; only entries below the stack pointer are ever read.
// Stalls:
//   The result register holds one item; characters keep being taken while it
//   waits. A second expression end stalls until the receiver takes the first.
//
`default_nettype none

module rpn_stack_calculator #(
    parameter int STACK_DEPTH   = 128,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  char_valid,
    output logic                       char_ready,
    input  wire rpn_pkg::char_item_t   char_item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output rpn_pkg::result_item_t      result_item
);
    import rpn_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_OPA   = 4'd2;
    localparam logic [3:0] S_OPB   = 4'd3;
    localparam logic [3:0] S_OPC   = 4'd4;
    localparam logic [3:0] S_ALU   = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_RDT   = 4'd7;
    localparam logic [3:0] S_CONV  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        error_reg, error_next;
    logic [2:0]        kind_reg,  kind_next;
    logic [MANT_W-1:0] mant_reg,  mant_next;
    logic [FDIG_W-1:0] fd_reg,    fd_next;
    logic              point_reg, point_next;
    logic              eend_reg,  eend_next;
    logic [1:0]        op_reg,    op_next;
    logic              rv_reg,    rv_next;
    logic [63:0]       first_reg;
    logic [63:0]       total_reg;
    logic [1:0]        status_reg;
    result_item_t      result_reg;

    // Character parse results
    logic              accept;
    logic              tok_end;
    logic [2:0]        p_kind;
    logic [MANT_W-1:0] p_mant;
    logic [FDIG_W-1:0] p_fd;
    logic              p_point;
    logic [1:0]        p_err;
    logic              is_digit;
    logic [3:0]        digit;
    logic [MANT_W+3:0] mant10;
    logic              finish;

    // Stack memory and units
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [63:0]       mem_wr_data;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [63:0]       mem_rd_data;
    logic [ADDR_W-1:0] idx_top, idx_next;
    logic              scale_start;
    logic              scale_done;
    logic [63:0]       scale_value;
    alu_req_t          alu_req;
    logic              alu_done;
    logic [63:0]       alu_result;

    // Result formatting
    logic [63:0]       t_mag, t_ip, t_lim, t_ipc;
    logic              load_result;

    assign accept   = char_valid && char_ready;
    assign tok_end  = char_item.token_end || char_item.expr_end;
    assign idx_top  = ADDR_W'(count_reg - CNT_W'(1));
    assign idx_next = ADDR_W'(count_reg - CNT_W'(2));

    // Digit accumulation, saturating at the mantissa maximum
    assign is_digit = (char_item.ch >= CH_ZERO) && (char_item.ch <= CH_NINE);
    assign digit    = 4'(char_item.ch - CH_ZERO);
    assign mant10   = (MANT_W+4)'({mant_reg, 3'b000}) + (MANT_W+4)'({mant_reg, 1'b0})
                    + (MANT_W+4)'(digit);

    // Character parsing
    always_comb
    begin
        logic num_char;
        num_char = 1'b0;
        p_kind   = kind_reg;
        p_mant   = mant_reg;
        p_fd     = fd_reg;
        p_point  = point_reg;
        p_err    = error_reg;
        if (error_reg == ST_OK)
        begin
            if (kind_reg == KIND_IDLE)
            begin
                if (char_item.ch == CH_PLUS)
                    p_kind = KIND_ADD;
                else if (char_item.ch == CH_TIMES)
                    p_kind = KIND_MUL;
                else if (char_item.ch == CH_MINUS)
                    p_kind = KIND_SUB;
                else
                begin
                    p_kind   = KIND_NUM;
                    num_char = 1'b1;
                end
            end
            else if (kind_reg == KIND_NUM)
            begin
                num_char = 1'b1;
            end
        end
        if (num_char)
        begin
            if ((char_item.ch == CH_POINT) && !point_reg)
            begin
                p_point = 1'b1;
            end
            else if (!is_digit)
            begin
                p_err = ST_BAD;
            end
            else
            begin
                if (point_reg && (fd_reg != FDIG_MAX))
                    p_fd = fd_reg + FDIG_W'(1);
                p_mant = (|mant10[MANT_W+3:MANT_W]) ? {MANT_W{1'b1}} : mant10[MANT_W-1:0];
            end
        end
    end

    assign finish = (p_err == ST_OK) && tok_end;

    // Integer part of the total, truncated toward zero and saturated
    assign t_mag = total_reg[63] ? (64'd0 - total_reg) : total_reg;
    assign t_ip  = t_mag >> FRACTION_BITS;
    assign t_lim = total_reg[63] ? INT40_MINU : INT40_MAXU;
    assign t_ipc = (t_ip > t_lim) ? t_lim : t_ip;

    assign load_result = (state_reg == S_CONV) && (!rv_reg || result_ready);

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        error_next  = error_reg;
        kind_next   = kind_reg;
        mant_next   = mant_reg;
        fd_next     = fd_reg;
        point_next  = point_reg;
        eend_next   = eend_reg;
        op_next     = op_reg;
        rv_next     = rv_reg && !result_ready;
        char_ready  = 1'b0;
        scale_start = 1'b0;
        alu_req     = '{start: 1'b0, op: op_reg};
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[ADDR_W-1:0];
        mem_wr_data = scale_value;
        mem_rd_addr = (state_reg == S_OPB) ? idx_next : idx_top;
        case (state_reg)
            S_IDLE:
            begin
                char_ready = 1'b1;
                if (accept)
                begin
                    eend_next  = char_item.expr_end;
                    error_next = p_err;
                    if (tok_end)
                    begin
                        kind_next  = KIND_IDLE;
                        mant_next  = '0;
                        fd_next    = '0;
                        point_next = 1'b0;
                    end
                    else
                    begin
                        kind_next  = p_kind;
                        mant_next  = p_mant;
                        fd_next    = p_fd;
                        point_next = p_point;
                    end
                    state_next = char_item.expr_end ? S_END : S_IDLE;
                    if (finish)
                    begin
                        if (p_kind == KIND_NUM)
                        begin
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                                error_next = ST_OVF;
                            else
                            begin
                                scale_start = 1'b1;
                                state_next  = S_SCALE;
                            end
                        end
                        else if (p_kind != KIND_IDLE)
                        begin
                            if (count_reg < CNT_W'(2))
                                error_next = ST_UNF;
                            else
                            begin
                                case (p_kind)
                                    KIND_MUL: op_next = OP_MUL;
                                    KIND_SUB: op_next = OP_SUB;
                                    default:  op_next = OP_ADD;
                                endcase
                                state_next = S_OPA;
                            end
                        end
                    end
                end
            end
            S_SCALE:
            begin
                if (scale_done)
                begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = eend_reg ? S_END : S_IDLE;
                end
            end
            S_OPA:
            begin
                state_next = S_OPB;
            end
            S_OPB:
            begin
                state_next = S_OPC;
            end
            S_OPC:
            begin
                alu_req.start = 1'b1;
                state_next    = S_ALU;
            end
            S_ALU:
            begin
                mem_wr_addr = idx_next;
                mem_wr_data = alu_result;
                if (alu_done)
                begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = eend_reg ? S_END : S_IDLE;
                end
            end
            S_END:
            begin
                if ((error_reg == ST_OK) && (count_reg != '0))
                    state_next = S_RDT;
                else
                    state_next = S_CONV;
            end
            S_RDT:
            begin
                state_next = S_CONV;
            end
            S_CONV:
            begin
                if (load_result)
                begin
                    rv_next    = 1'b1;
                    count_next = '0;
                    error_next = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            error_reg <= ST_OK;
            kind_reg  <= KIND_IDLE;
            mant_reg  <= '0;
            fd_reg    <= '0;
            point_reg <= 1'b0;
            eend_reg  <= 1'b0;
            op_reg    <= OP_ADD;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            error_reg <= error_next;
            kind_reg  <= kind_next;
            mant_reg  <= mant_next;
            fd_reg    <= fd_next;
            point_reg <= point_next;
            eend_reg  <= eend_next;
            op_reg    <= op_next;
            rv_reg    <= rv_next;
        end
    end

    // Operand capture, total and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OPB)
        begin
            first_reg <= mem_rd_data;
        end
        if (state_reg == S_END)
        begin
            total_reg  <= 64'd0;
            status_reg <= (error_reg == ST_OK) ? ST_UNF : error_reg;
        end
        if (state_reg == S_RDT)
        begin
            total_reg  <= mem_rd_data;
            status_reg <= ST_OK;
        end
        if (load_result)
        begin
            result_reg.total     <= total_reg;
            result_reg.total_int <= 40'(total_reg[63] ? (64'd0 - t_ipc) : t_ipc);
            result_reg.status    <= status_reg;
        end
    end

    rpn_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rpn_scale #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .mant   (p_mant),
        .digits (p_fd),
        .done   (scale_done),
        .value  (scale_value)
    );

    rpn_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (mem_rd_data),
        .b      (first_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign result_valid = rv_reg;
    assign result_item  = result_reg;

endmodule

`default_nettype wire

// ----- dv/tb_rpn_stack_calculator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator
// Streams reverse Polish expressions into the calculator one character per
// item, predicts each expression total and status in fixed point, and checks
// every result item against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_rpn_stack_calculator;

    import rpn_pkg::*;

    localparam int          STACK_DEPTH  = 128;
    localparam int          IDX_W        = $clog2(STACK_DEPTH);
    localparam int          FRAC_BITS    = 24;
    localparam longint      CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          SHOW_LIMIT   = 10;
    localparam int          RANDOM_CHARS = 550;
    localparam logic [63:0] MANT_LIMIT   = (64'd1 << MANT_W) - 64'd1;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         char_valid   = 1'b0;
    logic         char_ready;
    char_item_t   char_item    = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_item_t result_item;

    // Testbench bookkeeping
    result_item_t expected_results[$];
    int           mismatch_count  = 0;
    int           hold_off_cycles = 0;
    bit           idle_on         = 1'b1;
    bit           offering        = 1'b0;
    longint       cycle_count     = 0;
    int           chars_sent      = 0;

    // Calculator state as predicted
    logic [63:0]  val_stack [STACK_DEPTH];
    int unsigned  val_count;
    logic [39:0]  mant;
    logic [4:0]   frac_cnt;
    bit           has_point;
    logic [2:0]   cur_kind;
    logic [1:0]   err_state;

    rpn_stack_calculator #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed point arithmetic
    // ------------------------------------------------------------------

    // Saturating add or subtract on the 65-bit sign-extended sum
    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, bit subtract);
        logic [64:0] s;
        s = subtract ? {a[63], a} - {b[63], b} : {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? INT64_MIN : INT64_MAX;
        return s[63:0];
    endfunction

    // Full product of magnitudes, truncated toward zero, then saturated
    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0]  am;
        logic [63:0]  bm;
        logic [63:0]  r;
        logic [63:0]  lim;
        logic [127:0] p;
        bit           neg;
        neg = a[63] ^ b[63];
        am  = a[63] ? -a : a;
        bm  = b[63] ? -b : b;
        p   = {64'd0, am} * {64'd0, bm};
        p   = p >> FRAC_BITS;
        lim = neg ? INT64_MIN : INT64_MAX;
        r   = p[63:0];
        if (p[127:64] != '0 || r > lim)
            r = lim;
        return neg ? -r : r;
    endfunction

    // Mantissa scaled up, then divided by ten once per fraction digit
    function automatic logic [63:0] fixed_from_decimal(logic [39:0] m, logic [4:0] digits);
        logic [95:0] v;
        v = {56'd0, m} << FRAC_BITS;
        repeat (digits) v = v / 96'd10;
        if (v > {32'd0, INT64_MAX})
            return INT64_MAX;
        return v[63:0];
    endfunction

    // Integer part, toward zero, clamped to 40 bits signed
    function automatic logic [39:0] int_part(logic [63:0] t);
        logic [63:0] mag;
        logic [63:0] ip;
        logic [63:0] lim;
        mag = t[63] ? -t : t;
        ip  = mag >> FRAC_BITS;
        lim = t[63] ? INT40_MINU : INT40_MAXU;
        if (ip > lim)
            ip = lim;
        if (t[63])
            ip = -ip;
        return ip[39:0];
    endfunction

    // ------------------------------------------------------------------
    // Token and expression tracking
    // ------------------------------------------------------------------

    function automatic void reset_token();
        mant      = '0;
        frac_cnt  = '0;
        has_point = 1'b0;
        cur_kind  = KIND_IDLE;
    endfunction

    function automatic void reset_calc();
        val_count = 0;
        err_state = ST_OK;
        reset_token();
    endfunction

    function automatic void take_number_char(logic [7:0] c);
        logic [63:0] d;
        if (c == CH_POINT && !has_point)
        begin
            has_point = 1'b1;
            return;
        end
        if (c < CH_ZERO || c > CH_NINE)
        begin
            err_state = ST_BAD;
            return;
        end
        d = {56'd0, c} - {56'd0, CH_ZERO};
        if (has_point && frac_cnt < FDIG_MAX)
            frac_cnt = frac_cnt + 5'd1;
        if ({24'd0, mant} > (MANT_LIMIT - d) / 64'd10)
            mant = MANT_LIMIT[39:0];
        else
            mant = mant * 40'd10 + d[39:0];
    endfunction

    // Push a finished number, or pop two and push the operator result
    function automatic void close_token();
        logic [63:0] top_val;
        logic [63:0] next_val;
        logic [63:0] res;
        if (cur_kind == KIND_NUM)
        begin
            if (val_count >= STACK_DEPTH)
                err_state = ST_OVF;
            else
            begin
                val_stack[IDX_W'(val_count)] = fixed_from_decimal(mant, frac_cnt);
                val_count++;
            end
        end
        else if (cur_kind != KIND_IDLE)
        begin
            if (val_count < 2)
            begin
                err_state = ST_UNF;
                return;
            end
            top_val  = val_stack[IDX_W'(val_count - 1)];
            next_val = val_stack[IDX_W'(val_count - 2)];
            case (cur_kind)
                KIND_ADD: res = add_sat(next_val, top_val, 1'b0);
                KIND_MUL: res = mul_sat(next_val, top_val);
                default:  res = add_sat(next_val, top_val, 1'b1);
            endcase
            val_count--;
            val_stack[IDX_W'(val_count - 1)] = res;
        end
    endfunction

    // Advance the prediction by one accepted character
    function automatic void apply_char(char_item_t it);
        result_item_t res_item;
        logic [63:0]  top_val;
        if (err_state == ST_OK)
        begin
            if (cur_kind == KIND_IDLE)
            begin
                case (it.ch)
                    CH_PLUS:  cur_kind = KIND_ADD;
                    CH_TIMES: cur_kind = KIND_MUL;
                    CH_MINUS: cur_kind = KIND_SUB;
                    default:
                    begin
                        cur_kind = KIND_NUM;
                        take_number_char(it.ch);
                    end
                endcase
            end
            else if (cur_kind == KIND_NUM)
                take_number_char(it.ch);
            if (err_state == ST_OK && (it.token_end || it.expr_end))
                close_token();
        end
        if (it.token_end || it.expr_end)
            reset_token();
        if (!it.expr_end)
            return;

        // Expression end: pop the total and start over
        top_val         = '0;
        res_item.status = err_state;
        if (err_state == ST_OK)
        begin
            if (val_count == 0)
                res_item.status = ST_UNF;
            else
                top_val = val_stack[IDX_W'(val_count - 1)];
        end
        res_item.total     = top_val;
        res_item.total_int = int_part(top_val);
        expected_results.push_back(res_item);
        reset_calc();
    endfunction

    // ------------------------------------------------------------------
    // Character sender
    // ------------------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input bit tend, input bit eend);
        char_item_t it;
        it.ch        = c;
        it.token_end = tend;
        it.expr_end  = eend;
        if (idle_on && $urandom_range(99) < 20)
        begin
            if (offering)
                char_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= it;
        offering    = 1'b1;
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        apply_char(it);
        chars_sent++;
    endtask

    // Sender pauses until every predicted result has arrived
    task automatic wait_drained();
        if (offering)
            char_valid <= 1'b0;
        offering = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Last token carries expr_end; drop_tend leaves its token_end low
    task automatic send_tokens(input string toks[$], input bit drop_tend);
        string tok;
        bit    last_tok;
        bit    last_ch;
        for (int t = 0; t < toks.size(); t++)
        begin
            tok      = toks[t];
            last_tok = (t == toks.size() - 1);
            for (int i = 0; i < tok.len(); i++)
            begin
                last_ch = (i == tok.len() - 1);
                send_char(tok[i], last_ch && !(last_tok && drop_tend), last_ch && last_tok);
            end
        end
    endtask

    // Space separated expression text
    task automatic send_expr(input string text, input bit drop_tend = 1'b0);
        string toks[$];
        string cur;
        cur = "";
        for (int i = 0; i < text.len(); i++)
        begin
            if (text[i] == " ")
            begin
                if (cur.len() > 0)
                    toks.push_back(cur);
                cur = "";
            end
            else
                cur = {cur, text.substr(i, i)};
        end
        if (cur.len() > 0)
            toks.push_back(cur);
        send_tokens(toks, drop_tend);
    endtask

    // ------------------------------------------------------------------
    // Random token makers
    // ------------------------------------------------------------------

    function automatic string rand_number();
        string s;
        int    n_int;
        int    n_frac;
        int    r;
        s      = "";
        r      = $urandom_range(99);
        n_int  = $urandom_range(0, 4);
        n_frac = ($urandom_range(1) == 1) ? $urandom_range(0, 4) : -1;
        if (r < 3)
            n_int = $urandom_range(10, 15);
        else if (r < 5)
            n_frac = $urandom_range(12, 34);
        if (n_int == 0 && n_frac < 0)
            n_int = 1;
        repeat (n_int) s = $sformatf("%s%0d", s, $urandom_range(9));
        if (n_frac >= 0)
        begin
            s = {s, "."};
            repeat (n_frac) s = $sformatf("%s%0d", s, $urandom_range(9));
        end
        return s;
    endfunction

    // Operator, now and then with trailing junk that must be ignored
    function automatic string rand_operator();
        string s;
        case ($urandom_range(2))
            0:       s = "+";
            1:       s = "x";
            default: s = "-";
        endcase
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) s = $sformatf("%s%c", s, $urandom_range(1, 255));
        return s;
    endfunction

    // Well-formed expression with random values, sometimes broken on purpose
    task automatic send_random_expr();
        string toks[$];
        int    n_left;
        int    depth;
        int    keep;
        int    k;
        n_left = $urandom_range(1, 6);
        if ($urandom_range(9) == 0)
            n_left = $urandom_range(7, 20);
        keep  = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1;
        depth = 0;
        while (n_left > 0 || depth > keep)
        begin
            if (depth >= 2 && (n_left == 0 || $urandom_range(99) < 40))
            begin
                toks.push_back(rand_operator());
                depth--;
            end
            else
            begin
                toks.push_back(rand_number());
                depth++;
                n_left--;
            end
        end
        // Broken variants: leading operator, or a stray letter in a token
        k = $urandom_range(99);
        if (k < 4)
            toks.push_front(rand_operator());
        else if (k < 8)
        begin
            k       = $urandom_range(toks.size() - 1);
            toks[k] = {toks[k], "q"};
        end
        send_tokens(toks, $urandom_range(9) == 0);
    endtask

    // Arbitrary bytes with random token and expression flags
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(255)), $urandom_range(2) == 0,
                      (i == n - 1) || ($urandom_range(19) == 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operator, signs, bad characters, empty stack, operator tail
    task automatic test_directed();
        send_expr("3 4 +");
        send_expr("10 3 -");
        send_expr("1 5 -");
        send_expr("2.5 4 x");
        send_expr("0.5 2 -");
        send_expr(".");
        send_expr("1.2.3");
        send_expr("12a");
        send_char('0, 1'b1, 1'b1);
        send_char('1, 1'b1, 1'b1);
        send_expr("+");
        send_expr("5 -");
        send_expr("7 8 x9z");
        send_expr("4 5", 1'b1);
        wait_drained();
    endtask

    // Mantissa, fraction digit and arithmetic saturation
    task automatic test_number_limits();
        send_expr("999999999999");
        send_expr("12345678901234567");
        send_expr("0.0000000000000000000000000000000001");
        send_expr("123.4567890123456789012345678901234567");
        send_expr("549755813887 549755813887 +");
        send_expr("0 549755813887 - 549755813887 -");
        send_expr("1000000 1000000 x");
        send_expr("0 1000000 - 1000000 x");
        send_expr("0.1 0.1 x");
        send_expr("0 0.5 - 3 x");
        wait_drained();
    endtask

    // Fill the stack exactly, then once past full
    task automatic test_stack_full();
        repeat (STACK_DEPTH) send_char(CH_ZERO + 8'd1, 1'b1, 1'b0);
        repeat (STACK_DEPTH - 2) send_char(CH_PLUS, 1'b1, 1'b0);
        send_char(CH_PLUS, 1'b1, 1'b1);
        repeat (STACK_DEPTH + 1) send_char(CH_NINE, 1'b1, 1'b0);
        send_char(CH_PLUS, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Receiver holds off while short expressions keep coming
    task automatic test_backpressure();
        hold_off_cycles = 500;
        repeat (12) send_random_expr();
        wait_drained();
    endtask

    // Sender waits for each total before the next expression
    task automatic test_drain_between();
        repeat (15)
        begin
            send_random_expr();
            wait_drained();
        end
    endtask

    // Mostly well-formed random expressions, some noise
    task automatic test_random();
        int start;
        start   = chars_sent;
        idle_on = 1'b0;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            if (chars_sent - start > 300)
                idle_on = 1'b1;
            if ($urandom_range(99) < 85)
                send_random_expr();
            else
                send_noise();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: long hold-off on request, else always ready or, with idle_on, random stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_off_cycles--;
        end
        else if (idle_on)
            result_ready <= ($urandom_range(99) >= 20);
        else
            result_ready <= 1'b1;
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected result: total=%0d int=%0d status=%0d",
                             result_item.total, result_item.total_int, result_item.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_item.total !== want.total ||
                    result_item.total_int !== want.total_int ||
                    result_item.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("mismatch: expected total=%0d int=%0d status=%0d, got total=%0d int=%0d status=%0d",
                                 want.total, want.total_int, want.status,
                                 result_item.total, result_item.total_int, result_item.status);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        reset_calc();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_number_limits();
        test_stack_full();
        test_backpressure();
        test_drain_between();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
